[src/mscc_pkg.sv]
// ----------------------------------------------------------------------------
// mscc_pkg
// Shared types, constants and character/CRC helper functions for the MAC to
// serial-number codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mscc_pkg;

    localparam int unsigned MAC_LEN     = 12;
    localparam int unsigned SER_LEN     = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CHAR   = 2'd2,
        ERR_CRC    = 2'd3
    } err_code_t;

    typedef enum logic {
        MODE_TO_SERIAL = 1'b0,
        MODE_TO_MAC    = 1'b1
    } mode_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    // One finished run, handed from the intake side to the output side.
    typedef struct packed {
        mode_t       mode;
        err_code_t   err;
        logic [15:0] crc;
    } run_desc_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Digits go to A..J, hex letters of either case go to R..W, all else to 0.
    function automatic logic [7:0] map_to_serial(input logic [7:0] ch);
        logic [7:0] m;
        if (ch >= 8'h30 && ch <= 8'h39)
            m = ch + 8'h11;
        else if (ch >= 8'h61 && ch <= 8'h66)
            m = ch - 8'h0F;
        else if (ch >= 8'h41 && ch <= 8'h46)
            m = ch + 8'h11;
        else
            m = 8'h00;
        return m;
    endfunction

    // Inverse map: A..J back to digits, R..W back to uppercase A..F.
    function automatic logic [7:0] map_to_mac(input logic [7:0] ch);
        logic [7:0] m;
        if ((ch >= 8'h41 && ch <= 8'h4A) || (ch >= 8'h52 && ch <= 8'h57))
            m = ch - 8'h11;
        else
            m = 8'h00;
        return m;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = 8'h30 + {4'h0, v};
        else
            d = 8'h37 + {4'h0, v};
        return d;
    endfunction

endpackage

`default_nettype wire

[src/mac_serial_crc_codec_unit.sv]
// ----------------------------------------------------------------------------
// mac_serial_crc_codec_unit
// Converts a 12-digit MAC address to a 16-character serial number with
// interleaved CRC digits, and back.
//
// Input channel (in_valid / in_stall): one character per beat, in_last on the
// final one. The mode (func) is taken from the first beat of each string.
// Characters are taken one per cycle while no string is being emitted.
// Output channel (out_valid / out_stall): out_char per beat, out_last on the
// final beat, error_code nonzero on a single error beat with out_char zero.
// The final input beat's descriptor passes through the descriptor queue and
// the output side's descriptor register before the first of 16 (serial), 12
// (MAC) or 1 (error) result beats is registered; the rest follow one per cycle.
// Intake is stalled from the final input beat until the last result beat
// has been placed in the output register; the output side's read of the
// character store, one per cycle while out_stall is low, sets that window.
// A receiver stall holds the current result beat and halts the emission.
// Reset clears the run state, the descriptor queue and any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mac_serial_crc_codec_unit
    import mscc_pkg::*;
#(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_char,
    output logic             out_last,
    output logic [1:0]       error_code
);

    run_desc_t  push_desc;
    run_desc_t  head_desc;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    logic       back_busy;
    logic [3:0] rd_addr;
    logic [7:0] rd_data;

    mscc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .in_char     (in_char),
        .in_last     (in_last),
        .q_empty     (q_empty),
        .q_full      (q_full),
        .back_busy   (back_busy),
        .q_push      (q_push),
        .q_push_desc (push_desc),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    mscc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .empty     (q_empty),
        .full      (q_full)
    );

    mscc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .busy       (back_busy),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last),
        .error_code (error_code)
    );

endmodule

`default_nettype wire

[src/mscc_front.sv]
// ----------------------------------------------------------------------------
// mscc_front
// Intake side: takes one character per beat, maps it when converting to a
// serial number, updates the running CRC and the flags, stores it, and on the
// final character classifies the run into a descriptor for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscc_front
    import mscc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_last,
    input  wire logic        q_empty,
    input  wire logic        q_full,
    input  wire logic        back_busy,
    output logic             q_push,
    output run_desc_t        q_push_desc,
    input  wire logic [3:0]  rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0]  char_store_reg [SER_LEN];
    logic [4:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    mode_t       mode_reg, mode_next;
    logic        bad_reg, bad_next;
    logic        ovf_reg, ovf_next;

    logic        accept;
    mode_t       mode_eff;
    logic [7:0]  mapped;
    logic [7:0]  store_char;
    logic        in_range;
    logic        data_pos;
    logic        bad_now;
    logic [15:0] crc_upd;
    logic [4:0]  count_upd;
    logic        ovf_upd;
    logic        bad_upd;
    logic        crc_ok;
    err_code_t   err;

    // The store is owned by the output side from the final beat of a run
    // until its last result has been produced.
    assign in_stall = !q_empty || q_full || back_busy;
    assign accept   = in_valid && !in_stall;

    assign mode_eff   = (count_reg == 5'd0) ? mode_t'(func) : mode_reg;
    assign mapped     = map_to_serial(in_char);
    assign store_char = (mode_eff == MODE_TO_SERIAL) ? mapped : in_char;
    assign in_range   = !count_reg[4];

    always_comb
    begin
        if (mode_eff == MODE_TO_SERIAL)
            data_pos = in_range && (count_reg < 5'(MAC_LEN));
        else
            data_pos = in_range && (count_reg[1:0] != 2'd3);
    end

    always_comb
    begin
        if (mode_eff == MODE_TO_SERIAL)
            bad_now = data_pos && (mapped == 8'h00);
        else
            bad_now = data_pos && (map_to_mac(in_char) == 8'h00);
    end

    assign crc_upd   = data_pos ? crc_byte(crc_reg, store_char) : crc_reg;
    assign count_upd = in_range ? count_reg + 5'd1 : count_reg;
    assign ovf_upd   = ovf_reg || !in_range;
    assign bad_upd   = bad_reg || bad_now;

    // Check digits sit at positions 3, 7, 11 and 15; the last one is the
    // character arriving now whenever the length is right.
    assign crc_ok = (char_store_reg[3]  == hex_digit(crc_upd[15:12]))
                 && (char_store_reg[7]  == hex_digit(crc_upd[11:8]))
                 && (char_store_reg[11] == hex_digit(crc_upd[7:4]))
                 && (in_char            == hex_digit(crc_upd[3:0]));

    always_comb
    begin
        if (mode_eff == MODE_TO_SERIAL)
        begin
            priority if (ovf_upd || count_upd != 5'(MAC_LEN))
                err = ERR_LENGTH;
            else if (bad_upd)
                err = ERR_CHAR;
            else
                err = ERR_NONE;
        end
        else
        begin
            priority if (ovf_upd || count_upd != 5'(SER_LEN))
                err = ERR_LENGTH;
            else if (!crc_ok)
                err = ERR_CRC;
            else if (bad_upd)
                err = ERR_CHAR;
            else
                err = ERR_NONE;
        end
    end

    assign q_push           = accept && in_last;
    assign q_push_desc.mode = mode_eff;
    assign q_push_desc.err  = err;
    assign q_push_desc.crc  = crc_upd;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        mode_next  = mode_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            mode_next = mode_eff;
            if (in_last)
            begin
                count_next = 5'd0;
                crc_next   = CRC_INIT;
                bad_next   = 1'b0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_upd;
                crc_next   = crc_upd;
                bad_next   = bad_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
            crc_reg   <= CRC_INIT;
            mode_reg  <= MODE_TO_SERIAL;
            bad_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            mode_reg  <= mode_next;
            bad_reg   <= bad_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
            char_store_reg[count_reg[3:0]] <= store_char;
    end

    assign rd_data = char_store_reg[rd_addr];

endmodule

`default_nettype wire

[src/mscc_queue.sv]
// ----------------------------------------------------------------------------
// mscc_queue
// Short first-in first-out queue of run descriptors between the intake side
// and the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscc_queue
    import mscc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  run_desc_t      push_desc,
    input  wire logic      pop,
    output run_desc_t      head_desc,
    output logic           empty,
    output logic           full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    run_desc_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    assign head_desc = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[src/mscc_back.sv]
// ----------------------------------------------------------------------------
// mscc_back
// Output side: takes a run descriptor and produces the converted string from
// the character store, one beat per cycle while not stalled, or a single error beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscc_back
    import mscc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  run_desc_t        head_desc,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             busy,
    output logic [3:0]       rd_addr,
    input  wire logic [7:0]  rd_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_char,
    output logic             out_last,
    output logic [1:0]       error_code
);

    back_state_t state_reg, state_next;
    run_desc_t   desc_reg, desc_next;
    logic [1:0]  grp_reg, grp_next;
    logic [1:0]  sub_reg, sub_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;
    err_code_t   out_err_reg;

    logic        slot_free;
    logic        emit;
    logic        is_err;
    logic        is_check;
    logic        is_final;
    logic [3:0]  crc_nib;
    logic [7:0]  beat_char;
    logic        beat_last;

    assign slot_free = !out_valid_reg || !out_stall;
    assign is_err    = (desc_reg.err != ERR_NONE);
    assign is_check  = (desc_reg.mode == MODE_TO_SERIAL) && (sub_reg == 2'd3);

    always_comb
    begin
        if (desc_reg.mode == MODE_TO_SERIAL)
            is_final = (grp_reg == 2'd3) && (sub_reg == 2'd3);
        else
            is_final = (grp_reg == 2'd3) && (sub_reg == 2'd2);
    end

    // Serial form: three data characters then one CRC digit per group.
    // MAC form: the three data characters of each group of four.
    always_comb
    begin
        if (desc_reg.mode == MODE_TO_SERIAL)
            rd_addr = {1'b0, grp_reg, 1'b0} + {2'b00, grp_reg} + {2'b00, sub_reg};
        else
            rd_addr = {grp_reg, sub_reg};
    end

    always_comb
    begin
        unique case (grp_reg)
            2'd0:    crc_nib = desc_reg.crc[15:12];
            2'd1:    crc_nib = desc_reg.crc[11:8];
            2'd2:    crc_nib = desc_reg.crc[7:4];
            default: crc_nib = desc_reg.crc[3:0];
        endcase
    end

    always_comb
    begin
        priority if (is_err)
        begin
            beat_char = 8'h00;
            beat_last = 1'b1;
        end
        else if (is_check)
        begin
            beat_char = hex_digit(crc_nib);
            beat_last = is_final;
        end
        else if (desc_reg.mode == MODE_TO_SERIAL)
        begin
            beat_char = rd_data;
            beat_last = is_final;
        end
        else
        begin
            beat_char = map_to_mac(rd_data);
            beat_last = is_final;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                    state_next = BK_RUN;
            end
            BK_RUN:
            begin
                if (slot_free && beat_last)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        busy      = 1'b0;
        desc_next = desc_reg;
        grp_next  = grp_reg;
        sub_next  = sub_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    desc_next = head_desc;
                    grp_next  = 2'd0;
                    sub_next  = 2'd0;
                end
            end
            BK_RUN:
            begin
                busy = 1'b1;
                emit = slot_free;
                if (slot_free)
                begin
                    if ((desc_reg.mode == MODE_TO_SERIAL && sub_reg == 2'd3)
                        || (desc_reg.mode == MODE_TO_MAC && sub_reg == 2'd2))
                    begin
                        sub_next = 2'd0;
                        grp_next = grp_reg + 2'd1;
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        grp_reg  <= grp_next;
        sub_reg  <= sub_next;
        if (emit)
        begin
            out_char_reg <= beat_char;
            out_last_reg <= beat_last;
            out_err_reg  <= desc_reg.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_last   = out_last_reg;
    assign error_code = out_err_reg;

endmodule

`default_nettype wire

[src/mscc_checker.sv]
// ----------------------------------------------------------------------------
// mscc_checker
// Port-level checks on the codec's input and output channels, attached to
// the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mscc_checker
    import mscc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  out_char,
    input  wire logic        out_last,
    input  wire logic [1:0]  error_code
);

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char)
            && $stable(out_last) && $stable(error_code))
        else $error("result beat changed while stalled");

    // An error beat is always the only and final beat, with a zero character.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> out_char == 8'h00 && out_last)
        else $error("malformed error beat");

    // Converted characters are never zero.
    a_ok_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_NONE |-> out_char != 8'h00)
        else $error("zero character in a good result");

    // While a string is still being emitted, intake stays stalled.
    a_intake_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> in_stall)
        else $error("input taken while a string is being emitted");

endmodule

bind mac_serial_crc_codec_unit mscc_checker u_mscc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last),
    .error_code (error_code)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MAC / serial-number codec. Character strings are
// fed one beat at a time in both directions. The strings are valid ones,
// corrupted ones, and ones of the wrong length. A behavioral copy of the
// conversion predicts every output beat, and each output beat is compared
// field by field. Both handshake sides idle at random, and at one point the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb;
    import mscc_pkg::*;

    typedef struct {
        mode_t      mode;
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        err_code_t  err;
    } conv_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       func = 1'b0;
    logic [7:0] in_char = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] error_code;

    mac_serial_crc_codec_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .in_char    (in_char),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last),
        .error_code (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    char_beat_t char_feed[$];
    conv_beat_t expected_chars[$];
    logic [7:0] text[$];
    int         chars_queued = 0;
    int         beats_taken = 0;
    int         mismatches = 0;
    logic       in_fire_q = 1'b0;
    logic       out_fire_q = 1'b0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // Conversion state for the run in progress.
    logic [7:0]  run_chars [16];
    logic [4:0]  run_len = 5'd0;
    logic [15:0] run_crc = CRC_INIT;
    mode_t       run_mode = MODE_TO_SERIAL;
    logic        run_bad = 1'b0;
    logic        run_long = 1'b0;

    // Bitwise CRC-16/CCITT-FALSE, one byte at a time.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic logic [7:0] serial_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return ch - "0" + "A";
        if (ch >= "a" && ch <= "f")
            return ch - "a" + "R";
        if (ch >= "A" && ch <= "F")
            return ch - "A" + "R";
        return 8'h00;
    endfunction

    function automatic logic [7:0] mac_of(input logic [7:0] ch);
        if (ch >= "A" && ch <= "J")
            return ch - "A" + "0";
        if (ch >= "R" && ch <= "W")
            return ch - "R" + "A";
        return 8'h00;
    endfunction

    function automatic logic [7:0] hex_of(input logic [3:0] v);
        if (v < 4'd10)
            return "0" + {4'h0, v};
        return "A" + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [3:0] crc_nibble(input logic [15:0] crc, input int g);
        logic [15:0] sh;
        sh = crc >> (12 - 4 * g);
        return sh[3:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic expect_char(input logic [7:0] ch, input logic last, input err_code_t err);
        conv_beat_t r;
        r.ch = ch;
        r.last = last;
        r.err = err;
        expected_chars = {expected_chars, r};
    endtask

    // Advances the conversion by one input beat and queues whatever it emits.
    task automatic predict_conversion(input char_beat_t b);
        logic [7:0] m;
        logic       crc_ok;
        int         k;
        if (run_len == 0)
            run_mode = b.mode;
        if (run_len >= SER_LEN)
            run_long = 1'b1;
        else
        begin
            if (run_mode == MODE_TO_SERIAL)
            begin
                m = serial_of(b.ch);
                run_chars[run_len[3:0]] = m;
                if (run_len < MAC_LEN)
                begin
                    if (m == 8'h00)
                        run_bad = 1'b1;
                    run_crc = crc_update(run_crc, m);
                end
            end
            else
            begin
                run_chars[run_len[3:0]] = b.ch;
                // Every fourth character is a CRC digit and stays out of the sum.
                if (run_len[1:0] != 2'd3)
                begin
                    if (mac_of(b.ch) == 8'h00)
                        run_bad = 1'b1;
                    run_crc = crc_update(run_crc, b.ch);
                end
            end
            run_len = run_len + 5'd1;
        end

        if (!b.last)
            return;

        if (run_mode == MODE_TO_SERIAL)
        begin
            if (run_long || run_len != MAC_LEN)
                expect_char(8'h00, 1'b1, ERR_LENGTH);
            else if (run_bad)
                expect_char(8'h00, 1'b1, ERR_CHAR);
            else
            begin
                for (k = 0; k < SER_LEN; k++)
                begin
                    if (k % 4 == 3)
                        m = hex_of(crc_nibble(run_crc, k / 4));
                    else
                        m = run_chars[4'((k / 4) * 3 + k % 4)];
                    expect_char(m, k == SER_LEN - 1, ERR_NONE);
                end
            end
        end
        else
        begin
            if (run_long || run_len != SER_LEN)
                expect_char(8'h00, 1'b1, ERR_LENGTH);
            else
            begin
                crc_ok = 1'b1;
                for (k = 0; k < 4; k++)
                    if (run_chars[4'(k * 4 + 3)] != hex_of(crc_nibble(run_crc, k)))
                        crc_ok = 1'b0;
                if (!crc_ok)
                    expect_char(8'h00, 1'b1, ERR_CRC);
                else if (run_bad)
                    expect_char(8'h00, 1'b1, ERR_CHAR);
                else
                    for (k = 0; k < MAC_LEN; k++)
                        expect_char(mac_of(run_chars[4'((k / 3) * 4 + k % 3)]),
                                    k == MAC_LEN - 1, ERR_NONE);
            end
        end

        run_len = 5'd0;
        run_crc = CRC_INIT;
        run_bad = 1'b0;
        run_long = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // String building for the stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_mac_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text = {text, s[i]};
    endtask

    task automatic make_mac_text();
        text.delete();
        repeat (MAC_LEN)
            text = {text, rand_mac_char()};
    endtask

    task automatic map_text_to_serial();
        for (int i = 0; i < text.size(); i++)
            text[i] = serial_of(text[i]);
    endtask

    // Takes twelve raw data characters and inserts the CRC digits after every three.
    task automatic seal_serial_text();
        logic [7:0]  data[$];
        logic [15:0] crc;
        int          k;
        data = text;
        crc = CRC_INIT;
        for (k = 0; k < MAC_LEN; k++)
            crc = crc_update(crc, data[k]);
        text.delete();
        for (k = 0; k < MAC_LEN; k++)
        begin
            text = {text, data[k]};
            if (k % 3 == 2)
                text = {text, hex_of(crc_nibble(crc, k / 3))};
        end
    endtask

    // The block only looks at func on the first beat, so the rest get noise there.
    task automatic send_text(input mode_t md);
        char_beat_t b;
        for (int i = 0; i < text.size(); i++)
        begin
            b.mode = (i == 0) ? md : mode_t'($urandom_range(0, 1));
            b.ch = text[i];
            b.last = (i == text.size() - 1);
            char_feed = {char_feed, b};
        end
        chars_queued += text.size();
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    int tx_wait = 0;
    bit tx_steady = 1'b0;

    always @(negedge clk)
    begin : drive_proc
        char_beat_t b;
        if (rst_n && !(in_valid && !in_fire_q))
        begin
            if (in_valid)
            begin
                if ($urandom_range(0, 24) == 0)
                    tx_steady = !tx_steady;
                tx_wait = tx_steady ? 0 : $urandom_range(0, 14);
            end
            if (tx_wait != 0 || char_feed.size() == 0)
            begin
                if (tx_wait != 0)
                    tx_wait--;
                in_valid <= 1'b0;
            end
            else
            begin
                b = char_feed.pop_front();
                in_valid <= 1'b1;
                func <= b.mode;
                in_char <= b.ch;
                in_last <= b.last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver
    // ------------------------------------------------------------------
    int rx_wait = 0;
    bit rx_steady = 1'b0;

    always @(negedge clk)
    begin : recv_proc
        if (out_fire_q)
        begin
            if ($urandom_range(0, 24) == 0)
                rx_steady = !rx_steady;
            rx_wait = rx_steady ? 0 : $urandom_range(0, 14);
        end
        out_stall <= (rx_wait != 0) || (hold_left != 0);
        if (out_valid && rx_wait != 0)
            rx_wait--;
    end

    // One long hold-off on the output while the sender keeps offering beats.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && beats_taken >= 40)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every input beat, checks every output beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon_proc
        char_beat_t beat;
        conv_beat_t want;
        in_fire_q <= rst_n && in_valid && !in_stall;
        out_fire_q <= rst_n && out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            beat.mode = mode_t'(func);
            beat.ch = in_char;
            beat.last = in_last;
            predict_conversion(beat);
            beats_taken <= beats_taken + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                flag_mismatch($sformatf("unexpected beat char %h last %b err %0d",
                                        out_char, out_last, error_code));
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                    flag_mismatch($sformatf("out_char %h, expected %h", out_char, want.ch));
                if (out_last !== want.last)
                    flag_mismatch($sformatf("out_last %b, expected %b", out_last, want.last));
                if (error_code !== want.err)
                    flag_mismatch($sformatf("error_code %0d, expected %0d",
                                            error_code, want.err));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int kind;
        int len;
        int pos;

        // Directed: both letter cases and all digit ranges, a zero character at a
        // data position, and single-character strings in both modes.
        load_text("09aAfF5c3D1e");
        send_text(MODE_TO_SERIAL);
        load_text("7Bd0E2c4F6a8");
        text[5] = 8'h00;
        send_text(MODE_TO_SERIAL);
        load_text(" ");
        text[0] = 8'h00;
        send_text(MODE_TO_SERIAL);
        text[0] = 8'hFF;
        send_text(MODE_TO_MAC);

        while (chars_queued < 460)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                make_mac_text();
                send_text(MODE_TO_SERIAL);
            end
            else if (kind <= 5)
            begin
                make_mac_text();
                map_text_to_serial();
                seal_serial_text();
                send_text(MODE_TO_MAC);
            end
            else if (kind == 6)
            begin
                make_mac_text();
                text[$urandom_range(0, MAC_LEN - 1)] = $urandom_range(0, 1) ? 8'h00
                                                      : 8'($urandom_range(0, 255));
                send_text(MODE_TO_SERIAL);
            end
            else if (kind == 7)
            begin
                // Serial string with one character overwritten: mostly a CRC error.
                make_mac_text();
                map_text_to_serial();
                seal_serial_text();
                text[$urandom_range(0, SER_LEN - 1)] = 8'($urandom_range(0, 255));
                send_text(MODE_TO_MAC);
            end
            else if (kind == 8)
            begin
                // Bad data character under a matching CRC.
                make_mac_text();
                map_text_to_serial();
                text[$urandom_range(0, MAC_LEN - 1)] = 8'($urandom_range(0, 255));
                seal_serial_text();
                send_text(MODE_TO_MAC);
            end
            else
            begin
                len = $urandom_range(0, 1) ? $urandom_range(17, 20) : $urandom_range(1, 16);
                text.delete();
                for (pos = 0; pos < len; pos++)
                    if ($urandom_range(0, 1))
                        text = {text, 8'($urandom_range(0, 255))};
                    else
                        text = {text, serial_of(rand_mac_char())};
                send_text(mode_t'($urandom_range(0, 1)));
            end
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
src/mscc_pkg.sv
src/mscc_front.sv
src/mscc_queue.sv
src/mscc_back.sv
src/mac_serial_crc_codec_unit.sv
src/mscc_checker.sv
tb/tb.sv
